[rtl/cwtb_pkg.sv]
`timescale 1ns / 1ps

package cwtb_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// field widths
	localparam int REQ_W = 2;
	localparam int ID_W = 29;
	localparam int DLC_W = 4;
	localparam int DATA_W = 64;
	localparam int RATE_W = 16;
	localparam int VERDICT_W = 3;
	localparam int CNT_W = 32;
	localparam int TPS_W = 20;
	localparam int TICK_W = 32;
	localparam int TOK_W = 36;
	localparam int PROD_W = TICK_W + RATE_W;
	localparam int SUM_W = PROD_W + 1;

	localparam logic [DLC_W-1:0] MAX_DLC = DLC_W'(8);
	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_SEND  = 2'd1,
		REQ_LOAD  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_FORWARD = 3'd0,
		V_INVALID = 3'd1,
		V_BLOCKED = 3'd2,
		V_LIMITED = 3'd3,
		V_LOADED  = 3'd4,
		V_FULL    = 3'd5,
		V_DONE    = 3'd6
	} verdict_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MUL_CAP,
		S_MUL_REF,
		S_LEVEL,
		S_TAKE,
		S_LOAD_WR,
		S_DONE
	} state_t;

	// one whitelist entry as stored in the table ram
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rate_hz;
		logic [TOK_W-1:0]  tokens;
		logic [TICK_W-1:0] last_tick;
	} entry_t;

endpackage

[rtl/cwtb_req_if.sv]
`timescale 1ns / 1ps

interface cwtb_req_if;
	logic                          valid;
	logic                          ready;
	logic [cwtb_pkg::REQ_W-1:0]    req_type;
	logic [cwtb_pkg::ID_W-1:0]     can_id;
	logic [cwtb_pkg::DLC_W-1:0]    dlc;
	logic [cwtb_pkg::DATA_W-1:0]   payload;
	logic [cwtb_pkg::RATE_W-1:0]   entry_rate;

	modport source (output valid, output req_type, output can_id, output dlc,
		output payload, output entry_rate, input ready);
	modport sink (input valid, input req_type, input can_id, input dlc,
		input payload, input entry_rate, output ready);
endinterface

[rtl/cwtb_rsp_if.sv]
`timescale 1ns / 1ps

interface cwtb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [cwtb_pkg::VERDICT_W-1:0]  verdict;
	logic [cwtb_pkg::ID_W-1:0]       out_id;
	logic [cwtb_pkg::DLC_W-1:0]      out_dlc;
	logic [cwtb_pkg::DATA_W-1:0]     out_data;
	logic [cwtb_pkg::CNT_W-1:0]      sent_count;
	logic [cwtb_pkg::CNT_W-1:0]      blocked_count;
	logic [cwtb_pkg::CNT_W-1:0]      limited_count;

	modport source (output valid, output verdict, output out_id, output out_dlc,
		output out_data, output sent_count, output blocked_count,
		output limited_count, input ready);
	modport sink (input valid, input verdict, input out_id, input out_dlc,
		input out_data, input sent_count, input blocked_count,
		input limited_count, output ready);
endinterface

[rtl/cwtb_cfg_if.sv]
`timescale 1ns / 1ps

interface cwtb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cwtb_pkg::TPS_W-1:0]    ticks_per_second;

	modport source (output valid, output ticks_per_second, input ready);
	modport sink (input valid, input ticks_per_second, output ready);
endinterface

[rtl/can_id_whitelist_token_bucket.sv]
`timescale 1ns / 1ps
// Sequencing: tick, clear and invalid-length items go from idle straight to the done state,
// which raises rsp.valid; load and send items scan the table one entry per cycle, and a
// forwarded or limited send then runs the capacity multiply, refill multiply, level and
// take states on the shared 32x16 multiplier. One item at a time: req.ready is high only
// when idle, and a result still waiting at the output holds the sequencer in its last state.
// Reset: clears time, counters and valid bits, ticks_per_second to 1000; ram not cleared.

module can_id_whitelist_token_bucket (
	input logic         clk,
	input logic         arst_n,
	cwtb_req_if.sink    req,
	cwtb_rsp_if.source  rsp,
	cwtb_cfg_if.sink    cfg
);

	cwtb_pkg::state_t state_q, state_d;

	logic [cwtb_pkg::TPS_W-1:0]          tps_q;
	logic [cwtb_pkg::TPS_W-1:0]          scale;
	logic [cwtb_pkg::TICK_W-1:0]         now_q;
	logic [cwtb_pkg::TABLE_ENTRIES-1:0]  valid_q;

	// captured transaction
	cwtb_pkg::req_t                  req_type_q;
	logic [cwtb_pkg::ID_W-1:0]       id_q;
	logic [cwtb_pkg::DLC_W-1:0]      dlc_q;
	logic [cwtb_pkg::DATA_W-1:0]     data_q;
	logic [cwtb_pkg::RATE_W-1:0]     rate_q;

	// table scan
	logic [cwtb_pkg::IDX_W-1:0]  idx_q;
	logic                        issue_done_q;
	logic                        rd_pend_q;
	logic [cwtb_pkg::IDX_W-1:0]  rd_idx_q;
	logic                        free_found_q;
	logic [cwtb_pkg::IDX_W-1:0]  free_idx_q;
	logic [cwtb_pkg::IDX_W-1:0]  wr_idx_q;

	cwtb_pkg::entry_t  ent_q;
	cwtb_pkg::entry_t  ram_rdata;
	cwtb_pkg::entry_t  ram_wdata;
	logic              ram_we;
	logic              ram_re;

	// bucket arithmetic
	logic [cwtb_pkg::TICK_W-1:0]  mul_a;
	logic [cwtb_pkg::RATE_W-1:0]  mul_b;
	logic [cwtb_pkg::PROD_W-1:0]  prod_q;
	logic [cwtb_pkg::TOK_W-1:0]   cap_q;
	logic [cwtb_pkg::TOK_W-1:0]   level_q;
	logic [cwtb_pkg::SUM_W-1:0]   sum;
	logic                         take_ok;
	logic [cwtb_pkg::TOK_W-1:0]   new_tokens;
	cwtb_pkg::verdict_t           verdict_q;

	// result register
	logic                          rsp_valid_q;
	cwtb_pkg::verdict_t            verdict_out_q;
	logic [cwtb_pkg::ID_W-1:0]     out_id_q;
	logic [cwtb_pkg::DLC_W-1:0]    out_dlc_q;
	logic [cwtb_pkg::DATA_W-1:0]   out_data_q;
	logic [cwtb_pkg::CNT_W-1:0]    sent_q;
	logic [cwtb_pkg::CNT_W-1:0]    blocked_q;
	logic [cwtb_pkg::CNT_W-1:0]    limited_q;
	logic [cwtb_pkg::DATA_W-1:0]   masked_data;

	logic  in_accept;
	logic  dlc_bad;
	logic  hit;
	logic  miss;
	logic  out_free;
	logic  is_send;

	// handshake and decode
	assign req.ready = (state_q == cwtb_pkg::S_IDLE);
	assign in_accept = req.valid && req.ready;
	assign dlc_bad   = (req.dlc > cwtb_pkg::MAX_DLC);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign is_send   = (req_type_q == cwtb_pkg::REQ_SEND);
	assign cfg.ready = 1'b1;
	assign scale     = (tps_q == '0) ? cwtb_pkg::TPS_W'(1) : tps_q;

	// scan compare on the registered ram read
	assign hit  = (state_q == cwtb_pkg::S_SEARCH) && rd_pend_q && valid_q[rd_idx_q]
		&& (ram_rdata.id == id_q);
	assign miss = (state_q == cwtb_pkg::S_SEARCH) && !hit && issue_done_q && !rd_pend_q;

	cwtb_ram #(
		.WIDTH ($bits(cwtb_pkg::entry_t)),
		.DEPTH (cwtb_pkg::TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cwtb_pkg::S_IDLE: begin
				if (in_accept) begin
					case (cwtb_pkg::req_t'(req.req_type))
						cwtb_pkg::REQ_SEND: state_d = dlc_bad ? cwtb_pkg::S_DONE
							: cwtb_pkg::S_SEARCH;
						cwtb_pkg::REQ_LOAD: state_d = cwtb_pkg::S_SEARCH;
						default:            state_d = cwtb_pkg::S_DONE;
					endcase
				end
			end
			cwtb_pkg::S_SEARCH: begin
				if (hit) begin
					state_d = is_send ? cwtb_pkg::S_MUL_CAP : cwtb_pkg::S_DONE;
				end else if (miss) begin
					state_d = (!is_send && free_found_q) ? cwtb_pkg::S_MUL_CAP
						: cwtb_pkg::S_DONE;
				end
			end
			cwtb_pkg::S_MUL_CAP: state_d = is_send ? cwtb_pkg::S_MUL_REF : cwtb_pkg::S_LOAD_WR;
			cwtb_pkg::S_MUL_REF: state_d = cwtb_pkg::S_LEVEL;
			cwtb_pkg::S_LEVEL:   state_d = cwtb_pkg::S_TAKE;
			cwtb_pkg::S_TAKE:    state_d = cwtb_pkg::S_DONE;
			cwtb_pkg::S_LOAD_WR: state_d = cwtb_pkg::S_DONE;
			cwtb_pkg::S_DONE:    state_d = out_free ? cwtb_pkg::S_IDLE : cwtb_pkg::S_DONE;
			default:             state_d = cwtb_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ram_re    = (state_q == cwtb_pkg::S_SEARCH) && !issue_done_q;
		ram_we    = 1'b0;
		ram_wdata = ent_q;
		mul_a     = cwtb_pkg::TICK_W'(scale);
		mul_b     = is_send ? ent_q.rate_hz : rate_q;
		sum       = cwtb_pkg::SUM_W'(ent_q.tokens) + cwtb_pkg::SUM_W'(prod_q);
		take_ok   = (level_q >= cwtb_pkg::TOK_W'(scale));
		new_tokens = take_ok ? (level_q - cwtb_pkg::TOK_W'(scale)) : level_q;
		case (state_q)
			cwtb_pkg::S_MUL_REF: begin
				mul_a = now_q - ent_q.last_tick;
				mul_b = ent_q.rate_hz;
			end
			cwtb_pkg::S_TAKE: begin
				ram_we              = 1'b1;
				ram_wdata.tokens    = new_tokens;
				ram_wdata.last_tick = now_q;
			end
			cwtb_pkg::S_LOAD_WR: begin
				ram_we              = 1'b1;
				ram_wdata.id        = id_q;
				ram_wdata.rate_hz   = rate_q;
				ram_wdata.tokens    = prod_q[cwtb_pkg::TOK_W-1:0];
				ram_wdata.last_tick = now_q;
			end
			default: begin
			end
		endcase
	end

	// forwarded payload keeps only the bytes below dlc
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			masked_data[b*8 +: 8] = (cwtb_pkg::DLC_W'(b) < dlc_q) ? data_q[b*8 +: 8]
				: 8'h00;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cwtb_pkg::S_IDLE;
			tps_q        <= cwtb_pkg::TPS_RESET;
			now_q        <= '0;
			valid_q      <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			rd_pend_q    <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			sent_q       <= '0;
			blocked_q    <= '0;
			limited_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				tps_q <= cfg.ticks_per_second;
			end
			if (in_accept) begin
				idx_q        <= '0;
				issue_done_q <= 1'b0;
				rd_pend_q    <= 1'b0;
				free_found_q <= 1'b0;
				if (cwtb_pkg::req_t'(req.req_type) == cwtb_pkg::REQ_TICK) begin
					now_q <= now_q + 1'b1;
				end
				if (cwtb_pkg::req_t'(req.req_type) == cwtb_pkg::REQ_CLEAR) begin
					valid_q <= '0;
				end
			end
			// walk the table, remembering the lowest free slot
			if (state_q == cwtb_pkg::S_SEARCH) begin
				rd_pend_q <= ram_re;
				if (ram_re) begin
					if (idx_q == cwtb_pkg::LAST_IDX) begin
						issue_done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
			end
			if (state_q == cwtb_pkg::S_LOAD_WR) begin
				valid_q[wr_idx_q] <= 1'b1;
			end
			// result register and counters
			if ((state_q == cwtb_pkg::S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
				if (verdict_q == cwtb_pkg::V_FORWARD) begin
					sent_q <= sent_q + 1'b1;
				end
				if (verdict_q == cwtb_pkg::V_BLOCKED) begin
					blocked_q <= blocked_q + 1'b1;
				end
				if (verdict_q == cwtb_pkg::V_LIMITED) begin
					limited_q <= limited_q + 1'b1;
				end
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_q <= cwtb_pkg::req_t'(req.req_type);
			id_q       <= req.can_id;
			dlc_q      <= req.dlc;
			data_q     <= req.payload;
			rate_q     <= req.entry_rate;
			verdict_q  <= ((cwtb_pkg::req_t'(req.req_type) == cwtb_pkg::REQ_SEND) && dlc_bad)
				? cwtb_pkg::V_INVALID : cwtb_pkg::V_DONE;
		end
		if ((state_q == cwtb_pkg::S_SEARCH) && ram_re && !valid_q[idx_q]
				&& !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (hit) begin
			ent_q    <= ram_rdata;
			wr_idx_q <= rd_idx_q;
			if (!is_send) begin
				verdict_q <= cwtb_pkg::V_LOADED;
			end
		end else if (miss) begin
			if (is_send) begin
				verdict_q <= cwtb_pkg::V_BLOCKED;
			end else if (free_found_q) begin
				wr_idx_q <= free_idx_q;
			end else begin
				verdict_q <= cwtb_pkg::V_FULL;
			end
		end
		if (state_q == cwtb_pkg::S_SEARCH) begin
			rd_idx_q <= idx_q;
		end
		// shared multiplier: capacity, then refill amount
		if ((state_q == cwtb_pkg::S_MUL_CAP) || (state_q == cwtb_pkg::S_MUL_REF)) begin
			prod_q <= cwtb_pkg::PROD_W'(mul_a) * cwtb_pkg::PROD_W'(mul_b);
		end
		if (state_q == cwtb_pkg::S_MUL_REF) begin
			cap_q <= prod_q[cwtb_pkg::TOK_W-1:0];
		end
		// refill with saturation at the bucket capacity
		if (state_q == cwtb_pkg::S_LEVEL) begin
			level_q <= (sum > cwtb_pkg::SUM_W'(cap_q)) ? cap_q : sum[cwtb_pkg::TOK_W-1:0];
		end
		if (state_q == cwtb_pkg::S_TAKE) begin
			verdict_q <= take_ok ? cwtb_pkg::V_FORWARD : cwtb_pkg::V_LIMITED;
		end
		if (state_q == cwtb_pkg::S_LOAD_WR) begin
			verdict_q <= cwtb_pkg::V_LOADED;
		end
		if ((state_q == cwtb_pkg::S_DONE) && out_free) begin
			verdict_out_q <= verdict_q;
			if (verdict_q == cwtb_pkg::V_FORWARD) begin
				out_id_q   <= id_q;
				out_dlc_q  <= dlc_q;
				out_data_q <= masked_data;
			end else begin
				out_id_q   <= '0;
				out_dlc_q  <= '0;
				out_data_q <= '0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.verdict       = verdict_out_q;
	assign rsp.out_id        = out_id_q;
	assign rsp.out_dlc       = out_dlc_q;
	assign rsp.out_data      = out_data_q;
	assign rsp.sent_count    = sent_q;
	assign rsp.blocked_count = blocked_q;
	assign rsp.limited_count = limited_q;

endmodule

[rtl/cwtb_ram.sv]
`timescale 1ns / 1ps

module cwtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic                                           re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/cwtb_checker.sv]
`timescale 1ns / 1ps

module cwtb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [cwtb_pkg::VERDICT_W-1:0]   verdict,
	input logic [cwtb_pkg::ID_W-1:0]        out_id,
	input logic [cwtb_pkg::DLC_W-1:0]       out_dlc,
	input logic [cwtb_pkg::DATA_W-1:0]      out_data
);

	// the block works on one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous transaction in flight");

	// a fresh result only appears after a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while the engine was idle");

	// frame fields are zero unless the frame is forwarded
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict != cwtb_pkg::VERDICT_W'(cwtb_pkg::V_FORWARD))
		|-> (out_id == '0) && (out_dlc == '0) && (out_data == '0))
		else $error("frame fields set on non-forward verdict");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind can_id_whitelist_token_bucket cwtb_checker u_cwtb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.verdict   (rsp.verdict),
	.out_id    (rsp.out_id),
	.out_dlc   (rsp.out_dlc),
	.out_data  (rsp.out_data)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import cwtb_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 163;
	localparam logic [ID_W-1:0] ID_TOP = '1;

	typedef struct {
		req_t              kind;
		logic [ID_W-1:0]   can_id;
		logic [DLC_W-1:0]  dlc;
		logic [DATA_W-1:0] payload;
		logic [RATE_W-1:0] rate;
	} frame_req_t;

	typedef struct {
		verdict_t          verdict;
		logic [ID_W-1:0]   out_id;
		logic [DLC_W-1:0]  out_dlc;
		logic [DATA_W-1:0] out_data;
		logic [CNT_W-1:0]  sent_count;
		logic [CNT_W-1:0]  blocked_count;
		logic [CNT_W-1:0]  limited_count;
	} gate_rsp_t;

	typedef enum {PEND_FRAME, PEND_RATE, PEND_HOLD} pend_kind_e;

	typedef struct {
		pend_kind_e       kind;
		frame_req_t       item;
		logic [TPS_W-1:0] tps;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n;

	cwtb_req_if req();
	cwtb_rsp_if rsp();
	cwtb_cfg_if cfg();

	can_id_whitelist_token_bucket dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gate state mirror
	logic [TPS_W-1:0]  tps_now;
	logic [TICK_W-1:0] clock_ticks;
	logic              ent_used [TABLE_ENTRIES];
	logic [ID_W-1:0]   ent_id [TABLE_ENTRIES];
	logic [RATE_W-1:0] ent_rate [TABLE_ENTRIES];
	logic [TOK_W-1:0]  ent_tok [TABLE_ENTRIES];
	logic [TICK_W-1:0] ent_stamp [TABLE_ENTRIES];
	logic [CNT_W-1:0]  n_sent, n_blocked, n_limited;

	gate_rsp_t   outcome_q[$];
	pending_t    pending_q[$];
	logic [ID_W-1:0] gen_ids[$];

	int unsigned req_taken, cfg_taken, rsp_seen, quiet_cycles;
	int          errors;
	int          verdict_tally [8];

	function automatic logic [63:0] token_scale();
		return (tps_now == '0) ? 64'd1 : 64'(tps_now);
	endfunction

	function automatic int find_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (ent_used[i] && ent_id[i] == id)
				return i;
		return -1;
	endfunction

	// expected response for one request, updating the mirror
	function automatic gate_rsp_t gate_outcome(frame_req_t it);
		gate_rsp_t r;
		int slot;
		logic [63:0] scale, cap, level;
		logic [TICK_W-1:0] elapsed;
		r.verdict = V_DONE;
		r.out_id = '0;
		r.out_dlc = '0;
		r.out_data = '0;
		case (it.kind)
			REQ_TICK: begin
				clock_ticks = clock_ticks + 1'b1;
			end
			REQ_SEND: begin
				slot = find_slot(it.can_id);
				if (it.dlc > MAX_DLC) begin
					r.verdict = V_INVALID;
				end else if (slot < 0) begin
					n_blocked = n_blocked + 1'b1;
					r.verdict = V_BLOCKED;
				end else begin
					// lazy refill, clamp to the bucket size, then try one frame
					scale = token_scale();
					cap = scale * ent_rate[slot];
					elapsed = clock_ticks - ent_stamp[slot];
					level = ent_tok[slot] + elapsed * ent_rate[slot];
					if (level > cap)
						level = cap;
					ent_stamp[slot] = clock_ticks;
					if (level >= scale) begin
						level = level - scale;
						n_sent = n_sent + 1'b1;
						r.verdict = V_FORWARD;
						r.out_id = it.can_id;
						r.out_dlc = it.dlc;
						r.out_data = (it.dlc >= MAX_DLC) ? it.payload :
							it.payload & ((64'd1 << (8 * it.dlc)) - 64'd1);
					end else begin
						n_limited = n_limited + 1'b1;
						r.verdict = V_LIMITED;
					end
					ent_tok[slot] = level[TOK_W-1:0];
				end
			end
			REQ_LOAD: begin
				if (find_slot(it.can_id) >= 0) begin
					r.verdict = V_LOADED;
				end else begin
					r.verdict = V_FULL;
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						if (!ent_used[i]) begin
							ent_used[i] = 1'b1;
							ent_id[i] = it.can_id;
							ent_rate[i] = it.rate;
							ent_tok[i] = TOK_W'(token_scale() * it.rate);
							ent_stamp[i] = clock_ticks;
							r.verdict = V_LOADED;
							break;
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					ent_used[i] = 1'b0;
			end
		endcase
		r.sent_count = n_sent;
		r.blocked_count = n_blocked;
		r.limited_count = n_limited;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic bit id_listed(logic [ID_W-1:0] id);
		foreach (gen_ids[i])
			if (gen_ids[i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return ID_TOP;
			default: return ID_W'($urandom);
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return RATE_W'($urandom_range(0, 4));
		else if (sel < 8)
			return RATE_W'($urandom_range(5, 100));
		else if (sel == 8)
			return '1;
		else
			return RATE_W'($urandom);
	endfunction

	function automatic logic [DATA_W-1:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// queue one request and keep the generator's view of the table
	task automatic add_req(req_t kind, logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc,
			logic [DATA_W-1:0] data, logic [RATE_W-1:0] rate);
		pending_t p;
		p.kind = PEND_FRAME;
		p.item.kind = kind;
		p.item.can_id = id;
		p.item.dlc = dlc;
		p.item.payload = data;
		p.item.rate = rate;
		p.tps = '0;
		pending_q.push_back(p);
		if (kind == REQ_LOAD && !id_listed(id) && gen_ids.size() < TABLE_ENTRIES)
			gen_ids.push_back(id);
		if (kind == REQ_CLEAR)
			gen_ids.delete();
	endtask

	task automatic add_idle_req(req_t kind);
		add_req(kind, fresh_id(), DLC_W'($urandom), pick_payload(), RATE_W'($urandom));
	endtask

	task automatic add_pend(pend_kind_e kind, logic [TPS_W-1:0] tps);
		pending_t p;
		p.kind = kind;
		p.item.kind = REQ_TICK;
		p.item.can_id = '0;
		p.item.dlc = '0;
		p.item.payload = '0;
		p.item.rate = '0;
		p.tps = tps;
		pending_q.push_back(p);
	endtask

	// one rate setting worth of mixed traffic
	task automatic gen_phase(int count);
		int n, pick;
		logic [ID_W-1:0] id;
		n = 0;
		// clear or keep the table, then a run of loads that may overflow it
		if ($urandom_range(0, 1) == 1) begin
			add_idle_req(REQ_CLEAR);
			n++;
		end
		repeat ($urandom_range(2, TABLE_ENTRIES + 2)) begin
			add_req(REQ_LOAD, fresh_id(), DLC_W'($urandom), pick_payload(), pick_rate());
			n++;
		end
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 42 && gen_ids.size() != 0) begin
				// well-formed send on a whitelisted id
				id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
				add_req(REQ_SEND, id, DLC_W'($urandom_range(0, 8)), pick_payload(),
					RATE_W'($urandom));
				n++;
			end else if (pick < 50) begin
				add_req(REQ_SEND, fresh_id(), DLC_W'($urandom_range(0, 8)), pick_payload(),
					RATE_W'($urandom));
				n++;
			end else if (pick < 55) begin
				id = (gen_ids.size() != 0 && $urandom_range(0, 1) == 1) ?
					gen_ids[$urandom_range(0, gen_ids.size() - 1)] : fresh_id();
				add_req(REQ_SEND, id, DLC_W'($urandom_range(9, 15)), pick_payload(),
					RATE_W'($urandom));
				n++;
			end else if (pick < 79) begin
				repeat ($urandom_range(1, 6)) begin
					add_idle_req(REQ_TICK);
					n++;
				end
			end else if (pick < 93) begin
				id = (gen_ids.size() != 0 && $urandom_range(0, 3) == 0) ?
					gen_ids[$urandom_range(0, gen_ids.size() - 1)] : fresh_id();
				add_req(REQ_LOAD, id, DLC_W'($urandom), pick_payload(), pick_rate());
				n++;
			end else if (pick < 96) begin
				add_idle_req(REQ_CLEAR);
				n++;
			end else begin
				add_pend(PEND_HOLD, '0);
			end
		end
	endtask

	// request and register driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		pending_t   p;
		frame_req_t cur_item;
		logic       req_go, cfg_go;
		int         gap_left, burst_left;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= '0;
			req.can_id <= '0;
			req.dlc <= '0;
			req.payload <= '0;
			req.entry_rate <= '0;
			cfg.valid <= 1'b0;
			cfg.ticks_per_second <= TPS_RESET;
			gap_left = 0;
			burst_left = 0;
			req_taken = 0;
			cfg_taken = 0;
		end else begin
			req_go = req.valid && req.ready;
			cfg_go = cfg.valid && cfg.ready;
			if (req_go) begin
				outcome_q.push_back(gate_outcome(cur_item));
				req_taken++;
			end
			if (cfg_go) begin
				tps_now = cfg.ticks_per_second;
				cfg_taken++;
			end
			if ((req.valid && !req_go) || (cfg.valid && !cfg_go)) begin
				// transaction still waiting for ready
			end else if (gap_left > 0) begin
				gap_left--;
				req.valid <= 1'b0;
				cfg.valid <= 1'b0;
			end else if (pending_q.size() == 0) begin
				req.valid <= 1'b0;
				cfg.valid <= 1'b0;
			end else if (pending_q[0].kind == PEND_FRAME) begin
				p = pending_q.pop_front();
				cur_item = p.item;
				req.valid <= 1'b1;
				req.req_type <= p.item.kind;
				req.can_id <= p.item.can_id;
				req.dlc <= p.item.dlc;
				req.payload <= p.item.payload;
				req.entry_rate <= p.item.rate;
				cfg.valid <= 1'b0;
				// bursts of back-to-back requests separated by random gaps
				if (burst_left == 0) begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else if (req_taken != rsp_seen) begin
				// hold off until every response is back
				req.valid <= 1'b0;
				cfg.valid <= 1'b0;
			end else begin
				p = pending_q.pop_front();
				req.valid <= 1'b0;
				if (p.kind == PEND_RATE) begin
					cfg.valid <= 1'b1;
					cfg.ticks_per_second <= p.tps;
				end else begin
					cfg.valid <= 1'b0;
				end
			end
		end
	end

	// response checker with its own stall pattern
	always @(posedge clk or negedge arst_n) begin : watch_proc
		gate_rsp_t want;
		logic [7:0] stall_pat;
		logic [5:0] stall_step;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_seen <= 0;
			stall_pat = 8'hFF;
			stall_step = '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_seen <= rsp_seen + 1;
				verdict_tally[rsp.verdict]++;
				if (outcome_q.size() == 0) begin
					$error("response with no request waiting, verdict %0d", rsp.verdict);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("verdict", 64'(want.verdict), 64'(rsp.verdict));
					check_field("out_id", 64'(want.out_id), 64'(rsp.out_id));
					check_field("out_dlc", 64'(want.out_dlc), 64'(rsp.out_dlc));
					check_field("out_data", want.out_data, rsp.out_data);
					check_field("sent_count", 64'(want.sent_count), 64'(rsp.sent_count));
					check_field("blocked_count", 64'(want.blocked_count),
						64'(rsp.blocked_count));
					check_field("limited_count", 64'(want.limited_count),
						64'(rsp.limited_count));
				end
			end
			stall_step = stall_step + 1'b1;
			if (stall_step == '0) begin
				case ($urandom_range(0, 3))
					0, 1: stall_pat = 8'hFF;
					2: stall_pat = 8'($urandom) | 8'h01;
					default: stall_pat = 8'h01;
				endcase
			end
			rsp.ready <= stall_pat[stall_step[2:0]];
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [TPS_W-1:0] phase_tps [PHASES];
		arst_n = 1'b0;
		errors = 0;
		foreach (verdict_tally[i])
			verdict_tally[i] = 0;

		// mirror reset state
		tps_now = TPS_RESET;
		clock_ticks = '0;
		n_sent = '0;
		n_blocked = '0;
		n_limited = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			ent_used[i] = 1'b0;
			ent_id[i] = '0;
			ent_rate[i] = '0;
			ent_tok[i] = '0;
			ent_stamp[i] = '0;
		end

		// directed: bad length, unknown id, drain and refill, duplicates
		add_req(REQ_SEND, 29'h1234567, 4'd9, pick_payload(), 16'd7);
		add_req(REQ_SEND, '0, 4'd15, '1, '1);
		add_req(REQ_SEND, ID_TOP, 4'd0, pick_payload(), '0);
		add_req(REQ_LOAD, ID_TOP, '0, '0, 16'd2);
		add_req(REQ_SEND, ID_TOP, 4'd8, '1, '0);
		add_req(REQ_SEND, ID_TOP, 4'd3, '1, '0);
		add_req(REQ_SEND, ID_TOP, 4'd1, '1, '0);
		add_req(REQ_LOAD, '0, '1, '1, 16'd0);
		add_req(REQ_SEND, '0, 4'd8, '0, '1);
		add_req(REQ_LOAD, ID_TOP, '0, '0, '1);
		add_req(REQ_LOAD, 29'h0ABCDEF, '0, '0, '1);
		add_req(REQ_TICK, '1, '1, '1, '1);
		add_req(REQ_SEND, ID_TOP, 4'd0, '0, '0);
		// smaller scale: the big bucket gets clamped at its next refill
		add_pend(PEND_RATE, 20'd1);
		add_req(REQ_SEND, 29'h0ABCDEF, 4'd5, pick_payload(), '0);
		add_req(REQ_TICK, '0, '0, '0, '0);
		add_req(REQ_SEND, ID_TOP, 4'd7, pick_payload(), '0);
		// a zero scale behaves as one
		add_pend(PEND_RATE, 20'd0);
		add_req(REQ_SEND, '0, 4'd2, pick_payload(), '0);
		add_req(REQ_SEND, ID_TOP, 4'd4, pick_payload(), '0);
		add_req(REQ_CLEAR, '0, '0, '0, '0);
		add_req(REQ_SEND, 29'h0ABCDEF, 4'd6, pick_payload(), '0);
		add_req(REQ_TICK, '0, '0, '0, '0);
		add_pend(PEND_RATE, '1);
		add_req(REQ_LOAD, 29'h15555555, '0, '0, '1);
		add_req(REQ_SEND, 29'h15555555, 4'd8, 64'h5555_5555_AAAA_AAAA, '0);

		// random traffic over a range of scales
		phase_tps = '{20'd1, 20'd2, 20'd3, 20'd10, 20'd1000000, 20'd0, TPS_RESET, '1,
			TPS_W'($urandom_range(1, 50)), TPS_W'($urandom_range(4, 200))};
		for (int k = 0; k < PHASES; k++) begin
			add_pend(PEND_RATE, phase_tps[k]);
			gen_phase(PHASE_ITEMS);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the queue to empty and all responses to come back
		@(negedge clk);
		while (pending_q.size() != 0 || req.valid || cfg.valid || req_taken != rsp_seen)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (outcome_q.size() != 0) begin
			$error("%0d responses never arrived", outcome_q.size());
			errors++;
		end
		$display("checked %0d responses to %0d requests across %0d register writes",
			rsp_seen, req_taken, cfg_taken);
		$display("forward %0d, invalid %0d, blocked %0d, limited %0d, %s %0d, %s %0d, %s %0d",
			verdict_tally[V_FORWARD], verdict_tally[V_INVALID], verdict_tally[V_BLOCKED],
			verdict_tally[V_LIMITED], "loaded", verdict_tally[V_LOADED],
			"full", verdict_tally[V_FULL], "done", verdict_tally[V_DONE]);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/cwtb_pkg.sv
rtl/cwtb_req_if.sv
rtl/cwtb_rsp_if.sv
rtl/cwtb_cfg_if.sv
rtl/cwtb_ram.sv
rtl/can_id_whitelist_token_bucket.sv
rtl/cwtb_checker.sv
tb/testbench.sv
